@@ rtl/core/gsl_pkg.sv @@
package gsl_pkg;

  localparam int MAX_STRINGS_DEF = 8;
  localparam int MAX_LEN_DEF     = 64;
  localparam int OUT_LEN_W       = 10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       end_of_string;
    logic       end_of_set;
  } gsl_in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] superstring_length;
    logic                 overflow;
  } gsl_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAIR,
    ST_RD,
    ST_CMP,
    ST_AP_INIT,
    ST_AP_CHK,
    ST_AP_RD,
    ST_AP_WR,
    ST_AP_END,
    ST_EMIT
  } gsl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROUND_INIT,
    OP_PAIR_SKIP,
    OP_PAIR_ZERO,
    OP_PAIR_START,
    OP_READ,
    OP_CMP_NEXT,
    OP_CMP_SHORTER,
    OP_MATCH,
    OP_AP_INIT,
    OP_AP_READ,
    OP_AP_WRITE,
    OP_AP_END,
    OP_EMIT
  } gsl_op_t;

  typedef struct packed {
    gsl_op_t op;
  } gsl_cmd_t;

  typedef struct packed {
    logic pair_valid;
    logic pair_trivial;
    logic last_pair;
    logic char_eq;
    logic k_last;
    logic n_one;
    logic ap_more;
    logic rem_le1;
  } gsl_stat_t;

endpackage

@@ rtl/core/gsl_ram.sv @@
module gsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ rtl/core/gsl_ctrl.sv @@
module gsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              end_of_set,
  input  gsl_pkg::gsl_stat_t stat,
  output gsl_pkg::gsl_cmd_t  cmd,
  output logic              busy
);
  import gsl_pkg::*;

  gsl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start && end_of_set) state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = stat.rem_le1 ? ST_EMIT : ST_PAIR;
      ST_PAIR: begin
        if (stat.pair_valid && !stat.pair_trivial) begin
          state_nxt = ST_RD;
        end else if (stat.last_pair) begin
          state_nxt = ST_AP_INIT;
        end
      end
      ST_RD:      state_nxt = ST_CMP;
      ST_CMP: begin
        if (stat.char_eq && !stat.k_last) begin
          state_nxt = ST_RD;
        end else if (!stat.char_eq && !stat.n_one) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = stat.last_pair ? ST_AP_INIT : ST_PAIR;
        end
      end
      ST_AP_INIT: state_nxt = ST_AP_CHK;
      ST_AP_CHK:  state_nxt = stat.ap_more ? ST_AP_RD : ST_AP_END;
      ST_AP_RD:   state_nxt = ST_AP_WR;
      ST_AP_WR:   state_nxt = ST_AP_CHK;
      ST_AP_END:  state_nxt = ST_ROUND;
      ST_EMIT:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    busy   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = OP_LOAD;
      end
      ST_ROUND:   if (!stat.rem_le1) cmd.op = OP_ROUND_INIT;
      ST_PAIR: begin
        if (!stat.pair_valid) cmd.op = OP_PAIR_SKIP;
        else if (stat.pair_trivial) cmd.op = OP_PAIR_ZERO;
        else cmd.op = OP_PAIR_START;
      end
      ST_RD:      cmd.op = OP_READ;
      ST_CMP: begin
        if (stat.char_eq && stat.k_last) cmd.op = OP_MATCH;
        else if (stat.char_eq) cmd.op = OP_CMP_NEXT;
        else if (stat.n_one) cmd.op = OP_PAIR_ZERO;
        else cmd.op = OP_CMP_SHORTER;
      end
      ST_AP_INIT: cmd.op = OP_AP_INIT;
      ST_AP_CHK:  cmd.op = OP_NONE;
      ST_AP_RD:   cmd.op = OP_AP_READ;
      ST_AP_WR:   cmd.op = OP_AP_WRITE;
      ST_AP_END:  cmd.op = OP_AP_END;
      ST_EMIT:    cmd.op = OP_EMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/core/gsl_dp.sv @@
module gsl_dp #(
  parameter int S = gsl_pkg::MAX_STRINGS_DEF,
  parameter int L = gsl_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gsl_pkg::gsl_in_t   in_req,
  input  gsl_pkg::gsl_cmd_t  cmd,
  output gsl_pkg::gsl_stat_t stat,
  output gsl_pkg::gsl_out_t  out_res,
  output logic               out_valid
);
  import gsl_pkg::*;

  localparam int CAP   = S * L;
  localparam int DEPTH = S * CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(CAP + 1);
  localparam int SW    = (S > 1) ? $clog2(S) : 1;
  localparam int CW    = $clog2(S + 1);
  localparam logic [AW-1:0] CAP_A  = AW'(CAP);
  localparam logic [LW-1:0] CAP_L  = LW'(CAP);
  localparam logic [LW-1:0] MAXL_L = LW'(L);
  localparam logic [SW-1:0] LAST_S = SW'(S - 1);

  logic [LW-1:0] len_r [S];
  logic [LW-1:0] len_nxt [S];
  logic [S-1:0]  act_r, act_nxt;
  logic [CW-1:0] loaded_r, loaded_nxt, rem_r, rem_nxt;
  logic          ovf_r, ovf_nxt;
  logic [SW-1:0] i_r, i_nxt, j_r, j_nxt, wi_r, wi_nxt, wj_r, wj_nxt, surv_r, surv_nxt;
  logic [LW-1:0] best_r, best_nxt, n_r, n_nxt, k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  gsl_out_t      out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [7:0]    wr_data, rd_a, rd_b;

  logic [LW-1:0] la, lb, lwi, lwj, top;
  logic [SW-1:0] cur;
  logic          cur_ok;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] slot,
                                            input logic [LW-1:0] idx);
    return AW'(AW'(slot) * CAP_A) + AW'(idx);
  endfunction

  gsl_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign cur    = SW'(loaded_r);
  assign cur_ok = loaded_r < CW'(S);
  assign la     = len_r[i_r];
  assign lb     = len_r[j_r];
  assign lwi    = len_r[wi_r];
  assign lwj    = len_r[wj_r];
  assign top    = ((la - LW'(1)) < lb) ? (la - LW'(1)) : lb;

  assign stat.pair_valid   = act_r[i_r] && act_r[j_r] && (i_r != j_r);
  assign stat.pair_trivial = (la < LW'(2)) || (lb == '0);
  assign stat.last_pair    = (i_r == LAST_S) && (j_r == LAST_S);
  assign stat.char_eq      = rd_a == rd_b;
  assign stat.k_last       = k_r == (n_r - LW'(1));
  assign stat.n_one        = n_r == LW'(1);
  assign stat.ap_more      = (k_r < lwj) && (lwi < CAP_L);
  assign stat.rem_le1      = rem_r <= CW'(1);

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    len_nxt       = len_r;
    act_nxt       = act_r;
    loaded_nxt    = loaded_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    wi_nxt        = wi_r;
    wj_nxt        = wj_r;
    surv_nxt      = surv_r;
    best_nxt      = best_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = addr_of(cur, len_r[cur]);
    wr_data       = in_req.char_code;
    rd_addr_a     = addr_of(i_r, la - n_r + k_r);
    rd_addr_b     = addr_of(j_r, k_r);

    // pair advance shared by skip, zero and match; best update by zero and match
    if (cmd.op == OP_PAIR_ZERO || cmd.op == OP_MATCH) begin
      if ((cmd.op == OP_MATCH ? n_r : '0) >= best_r) begin
        best_nxt = (cmd.op == OP_MATCH) ? n_r : '0;
        wi_nxt   = i_r;
        wj_nxt   = j_r;
      end
    end
    if (cmd.op == OP_PAIR_SKIP || cmd.op == OP_PAIR_ZERO || cmd.op == OP_MATCH) begin
      if (j_r == LAST_S) begin
        j_nxt = '0;
        i_nxt = (i_r == LAST_S) ? '0 : i_r + SW'(1);
      end else begin
        j_nxt = j_r + SW'(1);
      end
    end

    unique case (cmd.op)
      OP_LOAD: begin
        if (in_req.char_valid) begin
          if (cur_ok && len_r[cur] < MAXL_L) begin
            wr_en        = 1'b1;
            len_nxt[cur] = len_r[cur] + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (in_req.end_of_string || in_req.end_of_set) begin
          if (cur_ok) begin
            act_nxt[cur] = 1'b1;
            loaded_nxt   = loaded_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        rem_nxt = loaded_nxt;
      end
      OP_ROUND_INIT: begin
        i_nxt    = '0;
        j_nxt    = '0;
        best_nxt = '0;
        wi_nxt   = '0;
        wj_nxt   = '0;
      end
      OP_PAIR_START: begin
        n_nxt = top;
        k_nxt = '0;
      end
      OP_CMP_NEXT:    k_nxt = k_r + LW'(1);
      OP_CMP_SHORTER: begin
        n_nxt = n_r - LW'(1);
        k_nxt = '0;
      end
      OP_AP_INIT:     k_nxt = best_r;
      OP_AP_READ:     rd_addr_b = addr_of(wj_r, k_r);
      OP_AP_WRITE: begin
        wr_en         = 1'b1;
        wr_addr       = addr_of(wi_r, lwi);
        wr_data       = rd_b;
        len_nxt[wi_r] = lwi + LW'(1);
        k_nxt         = k_r + LW'(1);
      end
      OP_AP_END: begin
        act_nxt[wj_r] = 1'b0;
        rem_nxt       = rem_r - CW'(1);
        surv_nxt      = wi_r;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nxt.superstring_length =
          (rem_r == CW'(1)) ? OUT_LEN_W'(len_r[surv_r]) : '0;
        out_nxt.overflow = ovf_r;
        for (int s = 0; s < S; s++) len_nxt[s] = '0;
        act_nxt    = '0;
        loaded_nxt = '0;
        rem_nxt    = '0;
        ovf_nxt    = 1'b0;
        surv_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < S; s++) len_r[s] <= '0;
      act_r       <= '0;
      loaded_r    <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      surv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      act_r       <= act_nxt;
      loaded_r    <= loaded_nxt;
      rem_r       <= rem_nxt;
      ovf_r       <= ovf_nxt;
      surv_r      <= surv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    wi_r   <= wi_nxt;
    wj_r   <= wj_nxt;
    best_r <= best_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ rtl/core/greedy_superstring_length_top.sv @@
// Greedy shortest-common-superstring length.
// Input: in_req carries one character (or an empty close) per request, taken
// when start is high and busy is low. end_of_string closes the current string;
// end_of_set closes it and starts the merge.
// Loading takes one cycle per request, back to back, characters going into a
// single-port-write, dual-read character RAM.
// After end_of_set, busy stays high while the merge runs. Each round scans all
// MAX_STRINGS^2 ordered slot pairs, compares characters with a RAM read then a
// compare, and appends characters with check, read and write steps; the round
// count is the number of strings minus one. This shared RAM port pair sets the
// merge time.
// The result appears on out_res with out_valid high for exactly one cycle, in
// the cycle busy falls; the receiver cannot stall it. All set state is then
// cleared and the next set may be loaded.
// Reset (rst_n low, synchronous) empties all slots; the character RAM needs no
// clearing since only written entries are ever read.
module greedy_superstring_length_top #(
  parameter int MAX_STRINGS = gsl_pkg::MAX_STRINGS_DEF,
  parameter int MAX_LEN     = gsl_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gsl_pkg::gsl_in_t  in_req,
  output logic              out_valid,
  output gsl_pkg::gsl_out_t out_res
);
  import gsl_pkg::*;

  gsl_cmd_t  cmd;
  gsl_stat_t stat;

  gsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .end_of_set (in_req.end_of_set),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  gsl_dp #(.S(MAX_STRINGS), .L(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_res   (out_res),
    .out_valid (out_valid)
  );

endmodule

@@ rtl/core/gsl_chk.sv @@
module gsl_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input gsl_pkg::gsl_in_t  in_req,
  input logic              out_valid,
  input gsl_pkg::gsl_out_t out_res
);

  a_set_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.end_of_set |=> busy)
    else $error("end of set did not start merge");

  a_out_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result without merge completion");

  a_done_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("merge finished without result");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_req.end_of_set |=> !busy && !out_valid)
    else $error("character request caused activity");

endmodule

bind greedy_superstring_length_top gsl_chk u_gsl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

@@ tb/greedy_superstring_length_top_tb.sv @@
module greedy_superstring_length_top_tb;
  import gsl_pkg::*;

  localparam int NSTR      = MAX_STRINGS_DEF;
  localparam int SLEN      = MAX_LEN_DEF;
  localparam int CAP       = NSTR * SLEN;
  localparam int CYC_LIMIT = 4000000;
  localparam int RAND_REQS = 1500;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  gsl_in_t  in_req;
  logic     out_valid;
  gsl_out_t out_res;

  greedy_superstring_length_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // shadow copy of the string slots
  logic [7:0] slot_chars [NSTR][CAP];
  int         slot_len   [NSTR];
  bit         slot_live  [NSTR];
  int         n_closed;
  bit         dropped;

  gsl_out_t   length_q[$];
  int         fails;
  int         reqs_sent;
  int         burst_left;
  longint     cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    gsl_out_t exp_res;
    if (rst_n && out_valid) begin
      if (length_q.size() == 0) begin
        $error("unexpected result: superstring_length %0d overflow %0d",
               out_res.superstring_length, out_res.overflow);
        fails++;
      end else begin
        exp_res = length_q.pop_front();
        if (out_res.superstring_length !== exp_res.superstring_length) begin
          $error("superstring_length: expected %0d, actual %0d",
                 exp_res.superstring_length, out_res.superstring_length);
          fails++;
        end
        if (out_res.overflow !== exp_res.overflow) begin
          $error("overflow: expected %0d, actual %0d",
                 exp_res.overflow, out_res.overflow);
          fails++;
        end
      end
    end
  end

  task automatic clear_sets();
    for (int s = 0; s < NSTR; s++) begin
      slot_len[s]  = 0;
      slot_live[s] = 1'b0;
    end
    n_closed = 0;
    dropped  = 1'b0;
  endtask

  function automatic int overlap_of(int a, int b);
    int la;
    int lb;
    int top;
    bit hit;
    la = slot_len[a];
    lb = slot_len[b];
    if (la < 2 || lb == 0) return 0;
    top = (la - 1 > lb) ? lb : la - 1;
    for (int n = top; n > 0; n--) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++)
        if (slot_chars[a][la - n + k] != slot_chars[b][k]) hit = 1'b0;
      if (hit) return n;
    end
    return 0;
  endfunction

  function automatic int merged_length();
    int left;
    int best;
    int wi;
    int wj;
    int q;
    left = 0;
    for (int i = 0; i < NSTR; i++) if (slot_live[i]) left++;
    while (left > 1) begin
      best = 0; wi = 0; wj = 0;
      for (int i = 0; i < NSTR; i++) begin
        if (!slot_live[i]) continue;
        for (int j = 0; j < NSTR; j++) begin
          if (!slot_live[j] || i == j) continue;
          q = overlap_of(i, j);
          if (q >= best) begin
            best = q; wi = i; wj = j;
          end
        end
      end
      for (int k = best; k < slot_len[wj] && slot_len[wi] < CAP; k++) begin
        slot_chars[wi][slot_len[wi]] = slot_chars[wj][k];
        slot_len[wi]++;
      end
      slot_live[wj] = 1'b0;
      left--;
    end
    for (int i = 0; i < NSTR; i++) if (slot_live[i]) return slot_len[i];
    return 0;
  endfunction

  task automatic take_request(gsl_in_t r);
    gsl_out_t e;
    if (r.char_valid) begin
      if (n_closed < NSTR && slot_len[n_closed] < SLEN) begin
        slot_chars[n_closed][slot_len[n_closed]] = r.char_code;
        slot_len[n_closed]++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (r.end_of_string || r.end_of_set) begin
      if (n_closed < NSTR) begin
        slot_live[n_closed] = 1'b1;
        n_closed++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (r.end_of_set) begin
      e.superstring_length = OUT_LEN_W'(merged_length());
      e.overflow           = dropped;
      length_q.push_back(e);
      clear_sets();
    end
  endtask

  task automatic send_req(logic [7:0] code, bit valid, bit eos, bit eoset);
    gsl_in_t r;
    int gap;
    r.char_code     = code;
    r.char_valid    = valid;
    r.end_of_string = eos;
    r.end_of_set    = eoset;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    take_request(r);
    burst_left--;
    reqs_sent++;
  endtask

  // one string; closed on its last character or by a separate empty request
  task automatic send_string(int len, logic [7:0] base, int span, bit last, bit fused);
    for (int k = 0; k < len; k++)
      send_req(base + 8'($urandom_range(0, span)), 1'b1,
               (k == len - 1) && fused && !last, (k == len - 1) && fused && last);
    if (len == 0 || !fused) send_req(8'($urandom), 1'b0, !last, last);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (length_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_edges();
    // single empty string, single character, extreme codes
    send_req(8'h00, 1'b0, 1'b0, 1'b1);
    send_req(8'hff, 1'b1, 1'b0, 1'b1);
    send_req(8'h00, 1'b1, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b0, 1'b0);
    send_req(8'h5a, 1'b0, 1'b0, 1'b0);   // idle request
    send_req(8'ha5, 1'b1, 1'b0, 1'b1);
    // "aaa" and "bcd", no overlap, plus an empty string in the middle
    send_string(3, 8'h61, 0, 1'b0, 1'b1);
    send_req(8'h00, 1'b0, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0, 1'b0);
    send_req(8'h63, 1'b1, 1'b0, 1'b0);
    send_req(8'h64, 1'b1, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_overflow();
    // long string past capacity
    send_string(SLEN + 3, 8'h30, 1, 1'b1, 1'b1);
    // too many strings: extra closes and characters dropped
    for (int s = 0; s < NSTR + 2; s++) send_string(2, 8'h41, 1, 1'b0, 1'b1);
    send_req(8'h42, 1'b1, 1'b0, 1'b1);
    // full capacity, single repeated character
    for (int s = 0; s < NSTR; s++) send_string(SLEN, 8'h7e, 0, s == NSTR - 1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_sets();
    int nstr;
    int len;
    int span;
    logic [7:0] base;
    while (reqs_sent < RAND_REQS) begin
      nstr = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, NSTR);
      span = $urandom_range(0, 9) == 0 ? 255 : $urandom_range(1, 2);
      base = (span == 255) ? 8'h00 : 8'($urandom);
      for (int s = 0; s < nstr; s++) begin
        if ($urandom_range(0, 19) == 0) send_req(8'($urandom), 1'b0, 1'b0, 1'b0);
        case ($urandom_range(0, 19))
          0:       len = 0;
          1:       len = $urandom_range(SLEN - 4, SLEN + 4);
          default: len = $urandom_range(1, 7);
        endcase
        send_string(len, base, span, s == nstr - 1, $urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 3) == 0) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    fails      = 0;
    reqs_sent  = 0;
    burst_left = 0;
    cycles     = 0;
    clear_sets();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_overflow();
    test_random_sets();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
